// ===== sv/hgcd_pkg.sv =====
package hgcd_pkg;

  typedef logic [29:0] atan_entry_t;

  localparam logic [30:0]        ONE_Q30      = 31'd1073741824;
  localparam logic [31:0]        PI_Q30       = 32'd3373259426;
  localparam logic [30:0]        HALF_PI_Q30  = 31'd1686629713;
  localparam logic signed [33:0] GAIN_Q30     = 34'sd652032874;
  localparam logic signed [30:0] LAT_LIMIT    = 31'sd754974720;
  localparam logic signed [33:0] DEG180_Q23   = 34'sd1509949440;
  localparam logic signed [33:0] DEG360_Q23   = 34'sd3019898880;
  localparam logic [62:0]        HALF_DIV180  = 63'd754974720;
  localparam logic [62:0]        HALF_DIV360  = 63'd1509949440;
  localparam logic [6:0]         DIV_SMALL    = 7'd45;
  localparam logic [23:0]        EARTH_DIAM_M = 24'd12742000;
  localparam logic [24:0]        DIST_MAX     = 25'd20015087;
  localparam int unsigned        ATAN_LEN     = 32;

  localparam atan_entry_t ATAN_Q30 [ATAN_LEN] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
    30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
    30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1024, 30'd511, 30'd255,
    30'd127, 30'd63, 30'd31, 30'd15, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
  };

  function automatic logic signed [30:0] clamp_lat(input logic signed [30:0] v);
    logic signed [30:0] r;
    if (v > LAT_LIMIT) r = LAT_LIMIT;
    else if (v < -LAT_LIMIT) r = -LAT_LIMIT;
    else r = v;
    return r;
  endfunction

  function automatic logic signed [31:0] clamp_unit(input logic signed [33:0] v);
    logic signed [33:0] r;
    if (v > $signed({3'b000, ONE_Q30})) r = $signed({3'b000, ONE_Q30});
    else if (v < -$signed({3'b000, ONE_Q30})) r = -$signed({3'b000, ONE_Q30});
    else r = v;
    return r[31:0];
  endfunction

  // eight quotient bits of a division by 45, remainder carried in and out
  function automatic logic [13:0] div45_byte(input logic [5:0] rem_in,
                                              input logic [7:0] bits);
    logic [6:0] t;
    logic [5:0] rem;
    logic [7:0] q;
    rem = rem_in;
    q   = '0;
    for (int k = 7; k >= 0; k--) begin
      t = {rem, bits[k]};
      if (t >= DIV_SMALL) begin
        q[k] = 1'b1;
        rem  = 6'(t - DIV_SMALL);
      end else begin
        rem = t[5:0];
      end
    end
    return {rem, q};
  endfunction

endpackage

// ===== sv/haversine_great_circle_distance_unit.sv =====
// Channel  Direction  Handshake               Payload
// in       input      in_valid / in_stall     in_lat_a, in_lon_a, in_lat_b, in_lon_b
// out      output     out_valid / out_stall   out_distance_m
//
// One transaction enters per cycle while no result is stalled; the depth is set by
// the two CORDIC chains (one stage per step) and the 31-stage square root pipeline.
// Synchronous active-low reset clears the stage valid bits only.
// A stalled result freezes the whole pipeline; in_stall follows it in the same cycle.
module haversine_great_circle_distance_unit
  import hgcd_pkg::*;
#(
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [30:0] in_lat_a,
  input  logic signed [31:0] in_lon_a,
  input  logic signed [30:0] in_lat_b,
  input  logic signed [31:0] in_lon_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [24:0]        out_distance_m
);

  localparam int N    = CORDIC_STEPS;
  localparam int SQN  = 31;
  localparam int L    = 48 + 2 * N;

  logic         adv;
  logic [L-1:0] vld_r;

  assign adv       = !(vld_r[L-1] && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld_r[L-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[L-2:0], in_valid};
    end
  end

  // clamp latitudes, raw longitude difference
  logic signed [30:0] a_la_r, a_lb_r;
  logic signed [32:0] a_dlon_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      a_la_r   <= clamp_lat(in_lat_a);
      a_lb_r   <= clamp_lat(in_lat_b);
      a_dlon_r <= {in_lon_b[31], in_lon_b} - {in_lon_a[31], in_lon_a};
    end
  end

  // latitude difference, wrap longitude difference
  logic signed [30:0] b_la_r, b_lb_r;
  logic signed [31:0] b_dlat_r, b_dlon_r;
  logic signed [33:0] dl_ext, dl_nxt;

  always_comb begin
    dl_ext = {a_dlon_r[32], a_dlon_r};
    if (dl_ext >= DEG180_Q23) dl_nxt = dl_ext - DEG360_Q23;
    else if (dl_ext < -DEG180_Q23) dl_nxt = dl_ext + DEG360_Q23;
    else dl_nxt = dl_ext;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_la_r   <= a_la_r;
      b_lb_r   <= a_lb_r;
      b_dlat_r <= {a_lb_r[30], a_lb_r} - {a_la_r[30], a_la_r};
      b_dlon_r <= dl_nxt[31:0];
    end
  end

  // lanes: 0 half dlat, 1 half dlon, 2 lat_a, 3 lat_b
  logic signed [31:0] c_ang [4];
  logic [30:0]        c_mag_r [4];
  logic               c_neg_r [4];

  always_comb begin
    c_ang[0] = b_dlat_r;
    c_ang[1] = b_dlon_r;
    c_ang[2] = {b_la_r[30], b_la_r};
    c_ang[3] = {b_lb_r[30], b_lb_r};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 4; l++) begin
        c_neg_r[l] <= c_ang[l][31];
        c_mag_r[l] <= c_ang[l][31] ? 31'(-c_ang[l]) : c_ang[l][30:0];
      end
    end
  end

  // scale by pi, round, pre-shift the power-of-two part of the divisor
  logic [62:0] d_sum [4];
  logic [36:0] d_x_r [4];
  logic        d_neg_r [4];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      d_sum[l] = 63'(c_mag_r[l]) * 63'(PI_Q30) + ((l < 2) ? HALF_DIV360 : HALF_DIV180);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 4; l++) begin
        d_neg_r[l] <= c_neg_r[l];
        d_x_r[l]   <= (l < 2) ? d_sum[l][62:26] : d_sum[l][61:25];
      end
    end
  end

  // divide by 45, one byte per stage
  logic [36:0] dv_x_r   [4][4];
  logic [5:0]  dv_rem_r [4][4];
  logic [31:0] dv_q_r   [4][4];
  logic        dv_neg_r [4][4];

  for (genvar k = 0; k < 4; k++) begin : g_div
    localparam int HI   = 31 - 8 * k;
    localparam int PREV = (k > 0) ? k - 1 : 0;
    logic [36:0] x_in   [4];
    logic [5:0]  rem_in [4];
    logic [31:0] q_in   [4];
    logic        neg_in [4];
    logic [13:0] res_nxt [4];

    always_comb begin
      for (int l = 0; l < 4; l++) begin
        if (k == 0) begin
          x_in[l]   = d_x_r[l];
          rem_in[l] = {1'b0, d_x_r[l][36:32]};
          q_in[l]   = '0;
          neg_in[l] = d_neg_r[l];
        end else begin
          x_in[l]   = dv_x_r[PREV][l];
          rem_in[l] = dv_rem_r[PREV][l];
          q_in[l]   = dv_q_r[PREV][l];
          neg_in[l] = dv_neg_r[PREV][l];
        end
        res_nxt[l] = div45_byte(rem_in[l], x_in[l][HI -: 8]);
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int l = 0; l < 4; l++) begin
          dv_x_r[k][l]   <= x_in[l];
          dv_rem_r[k][l] <= res_nxt[l][13:8];
          dv_q_r[k][l]   <= {q_in[l][23:0], res_nxt[l][7:0]};
          dv_neg_r[k][l] <= neg_in[l];
        end
      end
    end
  end

  // restore sign
  logic signed [33:0] s_z_r [4];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 4; l++) begin
        s_z_r[l] <= dv_neg_r[3][l] ? -$signed({2'b00, dv_q_r[3][l]})
                                   : $signed({2'b00, dv_q_r[3][l]});
      end
    end
  end

  // rotation CORDIC, one step per stage
  logic signed [33:0] rx_r [N][4];
  logic signed [33:0] ry_r [N][4];
  logic signed [33:0] rz_r [N][4];

  for (genvar i = 0; i < N; i++) begin : g_rot
    localparam logic signed [33:0] ATN = $signed({4'b0000, ATAN_Q30[i]});
    localparam int PREV = (i > 0) ? i - 1 : 0;
    logic signed [33:0] xi [4];
    logic signed [33:0] yi [4];
    logic signed [33:0] zi [4];

    always_comb begin
      for (int l = 0; l < 4; l++) begin
        if (i == 0) begin
          xi[l] = GAIN_Q30;
          yi[l] = '0;
          zi[l] = s_z_r[l];
        end else begin
          xi[l] = rx_r[PREV][l];
          yi[l] = ry_r[PREV][l];
          zi[l] = rz_r[PREV][l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int l = 0; l < 4; l++) begin
          if (zi[l] >= 0) begin
            rx_r[i][l] <= xi[l] - (yi[l] >>> i);
            ry_r[i][l] <= yi[l] + (xi[l] >>> i);
            rz_r[i][l] <= zi[l] - ATN;
          end else begin
            rx_r[i][l] <= xi[l] + (yi[l] >>> i);
            ry_r[i][l] <= yi[l] - (xi[l] >>> i);
            rz_r[i][l] <= zi[l] + ATN;
          end
        end
      end
    end
  end

  // clamp, take magnitudes of sines, drop negative cosines
  logic signed [31:0] p_su, p_sv, p_c1, p_c2;
  logic [30:0]        p_u_r, p_v_r, p_c1_r, p_c2_r;

  always_comb begin
    p_su = clamp_unit(ry_r[N-1][0]);
    p_sv = clamp_unit(ry_r[N-1][1]);
    p_c1 = clamp_unit(rx_r[N-1][2]);
    p_c2 = clamp_unit(rx_r[N-1][3]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_u_r  <= p_su[31] ? 31'(-p_su) : p_su[30:0];
      p_v_r  <= p_sv[31] ? 31'(-p_sv) : p_sv[30:0];
      p_c1_r <= p_c1[31] ? '0 : p_c1[30:0];
      p_c2_r <= p_c2[31] ? '0 : p_c2[30:0];
    end
  end

  logic [61:0] m1_uu_r, m1_vv_r, m1_cc_r;
  logic [61:0] rnd_uu, rnd_vv, rnd_cc;
  logic [30:0] r1_uu_r, r1_vv_r, r1_cc_r;
  logic [30:0] m2_uu_r;
  logic [61:0] m2_p_r;
  logic [61:0] rnd_p;
  logic [31:0] h_sum;
  logic [30:0] h_r;
  logic [30:0] q_s_r, q_c_r;

  assign rnd_uu = m1_uu_r + 62'(ONE_Q30 >> 1);
  assign rnd_vv = m1_vv_r + 62'(ONE_Q30 >> 1);
  assign rnd_cc = m1_cc_r + 62'(ONE_Q30 >> 1);
  assign rnd_p  = m2_p_r + 62'(ONE_Q30 >> 1);
  assign h_sum  = 32'(m2_uu_r) + 32'(rnd_p[60:30]);

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_uu_r <= 62'(p_u_r) * 62'(p_u_r);
      m1_vv_r <= 62'(p_v_r) * 62'(p_v_r);
      m1_cc_r <= 62'(p_c1_r) * 62'(p_c2_r);
      r1_uu_r <= rnd_uu[60:30];
      r1_vv_r <= rnd_vv[60:30];
      r1_cc_r <= rnd_cc[60:30];
      m2_uu_r <= r1_uu_r;
      m2_p_r  <= 62'(r1_cc_r) * 62'(r1_vv_r);
      h_r     <= (h_sum > 32'(ONE_Q30)) ? ONE_Q30 : h_sum[30:0];
      q_s_r   <= h_r;
      q_c_r   <= ONE_Q30 - h_r;
    end
  end

  // two integer square roots, one result bit per stage
  logic [61:0] sv_r [SQN][2];
  logic [61:0] sr_r [SQN][2];

  for (genvar j = 0; j < SQN; j++) begin : g_sqrt
    localparam logic [61:0] BIT = 62'd1 << (60 - 2 * j);
    localparam int PREV = (j > 0) ? j - 1 : 0;
    logic [61:0] vi [2];
    logic [61:0] ri [2];
    logic [62:0] sum_nxt [2];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        if (j == 0) begin
          vi[l] = {1'b0, ((l == 0) ? q_s_r : q_c_r), 30'b0};
          ri[l] = '0;
        end else begin
          vi[l] = sv_r[PREV][l];
          ri[l] = sr_r[PREV][l];
        end
        sum_nxt[l] = 63'(ri[l]) + 63'(BIT);
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int l = 0; l < 2; l++) begin
          if (63'(vi[l]) >= sum_nxt[l]) begin
            sv_r[j][l] <= vi[l] - sum_nxt[l][61:0];
            sr_r[j][l] <= (ri[l] >> 1) + BIT;
          end else begin
            sv_r[j][l] <= vi[l];
            sr_r[j][l] <= ri[l] >> 1;
          end
        end
      end
    end
  end

  // vectoring CORDIC: atan2(sqrt(h), sqrt(1-h))
  logic signed [33:0] vx_r [N];
  logic signed [33:0] vy_r [N];
  logic signed [33:0] vz_r [N];

  for (genvar i = 0; i < N; i++) begin : g_vec
    localparam logic signed [33:0] ATN = $signed({4'b0000, ATAN_Q30[i]});
    localparam int PREV = (i > 0) ? i - 1 : 0;
    logic signed [33:0] xi, yi, zi;

    always_comb begin
      if (i == 0) begin
        xi = $signed({3'b000, sr_r[SQN-1][1][30:0]});
        yi = $signed({3'b000, sr_r[SQN-1][0][30:0]});
        zi = '0;
      end else begin
        xi = vx_r[PREV];
        yi = vy_r[PREV];
        zi = vz_r[PREV];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (yi > 0) begin
          vx_r[i] <= xi + (yi >>> i);
          vy_r[i] <= yi - (xi >>> i);
          vz_r[i] <= zi + ATN;
        end else begin
          vx_r[i] <= xi - (yi >>> i);
          vy_r[i] <= yi + (xi >>> i);
          vz_r[i] <= zi - ATN;
        end
      end
    end
  end

  // scale angle to metres, round, saturate
  logic [30:0] f_ang;
  logic [54:0] f_p_r;
  logic [54:0] f_rnd;
  logic [24:0] dist_nxt;
  logic [24:0] out_distance_m_r;

  always_comb begin
    if (vz_r[N-1] < 0) f_ang = '0;
    else if (vz_r[N-1] > $signed({3'b000, HALF_PI_Q30})) f_ang = HALF_PI_Q30;
    else f_ang = vz_r[N-1][30:0];
    f_rnd    = f_p_r + 55'(ONE_Q30 >> 1);
    dist_nxt = (f_rnd[54:30] > DIST_MAX) ? DIST_MAX : f_rnd[54:30];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_p_r            <= 55'(f_ang) * 55'(EARTH_DIAM_M);
      out_distance_m_r <= dist_nxt;
    end
  end

  assign out_distance_m = out_distance_m_r;

  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline moved during a stall");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_distance_m <= DIST_MAX))
    else $error("distance beyond half circumference");

endmodule

// ===== dv/tb_haversine_great_circle_distance_unit.sv =====
`timescale 1ns / 1ps

module tb_haversine_great_circle_distance_unit;
  import hgcd_pkg::*;

  localparam int STEPS      = 24;
  localparam int LATENCY    = 48 + 2 * STEPS;
  localparam int N_RANDOM   = 550;
  localparam int IDLE_LIMIT = 20000;

  localparam longint L_ONE   = 64'd1073741824;
  localparam longint L_HPI   = 64'd1686629713;
  localparam longint L_PI    = 64'd3373259426;
  localparam longint L_GAIN  = 64'd652032874;
  localparam longint L_LAT   = 64'd754974720;
  localparam longint L_D180  = 64'd1509949440;
  localparam longint L_D360  = 64'd3019898880;
  localparam longint L_DIAM  = 64'd12742000;
  localparam longint L_DMAX  = 64'd20015087;

  localparam longint ARCTAN [32] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
    131071, 65535, 32767, 16383, 8191, 4095, 2047, 1024, 511, 255,
    127, 63, 31, 15, 8, 4, 2, 1, 0
  };

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [30:0] in_lat_a;
  logic signed [31:0] in_lon_a;
  logic signed [30:0] in_lat_b;
  logic signed [31:0] in_lon_b;
  logic               out_valid;
  logic               out_stall;
  logic [24:0]        out_distance_m;

  haversine_great_circle_distance_unit #(.CORDIC_STEPS(STEPS)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_lat_a(in_lat_a), .in_lon_a(in_lon_a),
    .in_lat_b(in_lat_b), .in_lon_b(in_lon_b),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_distance_m(out_distance_m)
  );

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip_unit(longint v);
    if (v > L_ONE) return L_ONE;
    if (v < -L_ONE) return -L_ONE;
    return v;
  endfunction

  function automatic longint deg_to_rad(longint d, longint dv);
    longint mag;
    longint r;
    mag = (d < 0) ? -d : d;
    r = longint'((64'(mag) * 64'(L_PI) + 64'(dv / 2)) / 64'(dv));
    return (d < 0) ? -r : r;
  endfunction

  function automatic void rotate_sincos(longint a, output longint sn, output longint cs);
    longint x, y, z, dx, dy;
    x = L_GAIN; y = 0; z = a;
    for (int i = 0; i < STEPS && i < 32; i++) begin
      dx = shr_floor(y, i); dy = shr_floor(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= ARCTAN[i];
      end else begin
        x += dx; y -= dy; z += ARCTAN[i];
      end
    end
    sn = clip_unit(y);
    cs = clip_unit(x);
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < STEPS && i < 32; i++) begin
      dx = shr_floor(y, i); dy = shr_floor(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += ARCTAN[i];
      end else begin
        x -= dx; y += dy; z -= ARCTAN[i];
      end
    end
    if (z < 0) z = 0;
    if (z > L_HPI) z = L_HPI;
    return z;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0; b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b; r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  function automatic longint lat_limit(logic signed [30:0] v);
    longint w;
    w = longint'(v);
    if (w > L_LAT) return L_LAT;
    if (w < -L_LAT) return -L_LAT;
    return w;
  endfunction

  function automatic logic [24:0] great_circle_m(logic signed [30:0] lat_a,
                                                 logic signed [31:0] lon_a,
                                                 logic signed [30:0] lat_b,
                                                 logic signed [31:0] lon_b);
    longint la, lb, dlon, u, v, c, s, c1, c2, ang;
    longint unsigned uu, vv, cc, h, sq, cq, metres;
    la = lat_limit(lat_a);
    lb = lat_limit(lat_b);
    dlon = (((longint'(lon_b) - longint'(lon_a)) % L_D360) + L_D360) % L_D360;
    if (dlon >= L_D180) dlon -= L_D360;
    rotate_sincos(deg_to_rad(lb - la, L_D360), u, c);
    rotate_sincos(deg_to_rad(dlon, L_D360), v, c);
    rotate_sincos(deg_to_rad(la, L_D180), s, c1);
    rotate_sincos(deg_to_rad(lb, L_D180), s, c2);
    if (c1 < 0) c1 = 0;
    if (c2 < 0) c2 = 0;
    if (u < 0) u = -u;
    if (v < 0) v = -v;
    uu = qmul(u, u);
    vv = qmul(v, v);
    cc = qmul(c1, c2);
    h = uu + qmul(cc, vv);
    if (h > L_ONE) h = L_ONE;
    sq = int_sqrt(h << 30);
    cq = int_sqrt((L_ONE - h) << 30);
    ang = vector_angle(longint'(sq), longint'(cq));
    metres = (64'(ang) * L_DIAM + (64'd1 << 29)) >> 30;
    if (metres > L_DMAX) metres = L_DMAX;
    return metres[24:0];
  endfunction

  class distance_scoreboard;
    logic [24:0] pending_dist[$];
    int          n_checked;
    int          n_mismatch;

    function void note_input(logic signed [30:0] la, logic signed [31:0] oa,
                             logic signed [30:0] lb, logic signed [31:0] ob);
      pending_dist.push_back(great_circle_m(la, oa, lb, ob));
    endfunction

    function void check_result(logic [24:0] got);
      logic [24:0] want;
      if (pending_dist.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result distance_m=%0d", got);
        return;
      end
      want = pending_dist.pop_front();
      n_checked++;
      if (got !== want) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("distance_m mismatch: expected %0d actual %0d", want, got);
      end
    endfunction
  endclass

  distance_scoreboard sb;
  int idle_cycles;
  int n_sent;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // receiver stall pattern: phases of free flow, light and heavy stalling
  int stall_phase;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_phase <= 0;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_phase <= $urandom_range(0, 2);
      case (stall_phase)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_distance_m);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("haversine_great_circle_distance_unit regression: fail");
        $finish;
      end
    end
  end

  task automatic send_point_pair(logic signed [30:0] la, logic signed [31:0] oa,
                                 logic signed [30:0] lb, logic signed [31:0] ob);
    in_valid <= 1'b1;
    in_lat_a <= la; in_lon_a <= oa; in_lat_b <= lb; in_lon_b <= ob;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(la, oa, lb, ob);
    n_sent++;
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic signed [30:0] rand_lat();
    case ($urandom_range(0, 5))
      0: return 31'($urandom);
      1: return $urandom_range(0, 1) ? 31'sd754974720 : -31'sd754974720;
      default: return 31'(longint'($urandom_range(0, 1509949440)) - L_LAT);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_lon();
    case ($urandom_range(0, 5))
      0: return 32'($urandom);
      1: return $urandom_range(0, 1) ? 32'sd1509949440 : -32'sd1509949440;
      default: return 32'(longint'($urandom) % (2 * L_D180 + 1) - L_D180);
    endcase
  endfunction

  logic signed [30:0] la_r, lb_r;
  logic signed [31:0] oa_r, ob_r;
  int burst;

  initial begin
    sb = new();
    idle_cycles = 0;
    n_sent = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_lat_a <= '0; in_lon_a <= '0; in_lat_b <= '0; in_lon_b <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_point_pair(0, 0, 0, 0);
    send_point_pair(31'sd754974720, 0, -31'sd754974720, 0);
    send_point_pair(0, 0, 0, 32'sd1509949440);
    send_point_pair(0, -32'sd1509949440, 0, 32'sd1509949440);
    send_point_pair(0, 32'sd1509949440, 0, -32'sd1509949440);
    send_point_pair(0, 32'sh7FFFFFFF, 0, 32'sh80000000);
    send_point_pair(0, 32'sh80000000, 0, 32'sh7FFFFFFF);
    send_point_pair(31'sh3FFFFFFF, 0, 31'sh40000000, 0);
    send_point_pair(31'sh40000000, 5, 31'sh3FFFFFFF, -5);
    send_point_pair(31'sd754974720, 32'sd123456789, 31'sd754974720, -32'sd987654321);
    send_point_pair(-31'sd754974720, 0, -31'sd754974720, 32'sd1509949440);
    send_point_pair(0, 0, 0, 32'sd1509949439);
    send_point_pair(1, 0, 0, 0);
    send_point_pair(0, 0, 0, 1);
    send_point_pair(0, 0, 0, -1);
    send_point_pair(31'sd377487360, 32'sd754974720, -31'sd377487360, -32'sd754974720);
    send_point_pair(31'sh7FFFFFFF, 32'shFFFFFFFF, 31'sh00000000, 32'sh00000000);
    idle_gap(3);

    while (n_sent < N_RANDOM + 17) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        la_r = rand_lat(); lb_r = rand_lat();
        oa_r = rand_lon(); ob_r = rand_lon();
        if ($urandom_range(0, 4) == 0) begin
          lb_r = la_r + 31'($signed(10'($urandom)));
          ob_r = oa_r + 32'($signed(10'($urandom)));
        end else if ($urandom_range(0, 6) == 0) begin
          lb_r = -la_r;
          ob_r = oa_r + 32'sd1509949440 + 32'($signed(8'($urandom)));
        end
        send_point_pair(la_r, oa_r, lb_r, ob_r);
      end
      idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
    end
    in_valid <= 1'b0;

    while (sb.pending_dist.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    $display("point pairs sent: %0d, distances checked: %0d, mismatches: %0d",
             n_sent, sb.n_checked, sb.n_mismatch);
    $display("covered poles, antimeridian wrap, antipodes, latitude clamping, near pairs");
    if (sb.n_mismatch == 0 && sb.pending_dist.size() == 0)
      $display("haversine_great_circle_distance_unit regression: pass");
    else
      $display("haversine_great_circle_distance_unit regression: fail");
    $finish;
  end

endmodule
